>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the shuffled random generator.
// The asserting module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SLRG_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SLRG_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/slrg_pkg.sv
// Package of the shuffled random generator: widths, constants, item types, states.
// Used by every module of the block except slrg_ram; depends on nothing.
`default_nettype none

package slrg_pkg;

    localparam int VAL_W      = 31;
    localparam int FRAC_W     = 24;
    localparam int FRAC_SHIFT = VAL_W - FRAC_W;
    localparam int MULT_W     = 15;
    localparam int PROD_W     = VAL_W + MULT_W;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    // Modulus 2^31 - 1, one bit wider than a value so that sums compare against it.
    localparam logic [VAL_W:0]    LCG_MOD  = 32'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

    // Shuffle table depth; a power of two from 2 to 64. The entry index is then
    // simply the top bits of the shuffle output.
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SEED_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(SEED_STEPS);

    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] seed;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]  raw_value;
        logic [FRAC_W-1:0] fraction;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_FOLD,
        ST_DRAW,
        ST_DRAW_FOLD
    } t_state;

    // Control decoded by the sequencer for the generator core and the table.
    typedef struct packed {
        logic             lcg_start;
        logic             ram_re;
        logic             ram_we;
        logic [IDX_W-1:0] ram_waddr;
    } t_ctrl;

endpackage

`default_nettype wire

>>> rtl/slrg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package needed.
`default_nettype none

module slrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the entry being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/slrg_lcg.sv
// Multiplicative congruential step x * 16807 mod (2^31 - 1), product registered.
// Depends on slrg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slrg_lcg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [slrg_pkg::VAL_W-1:0] i_x,
    output      logic                       o_valid,
    output      logic [slrg_pkg::VAL_W-1:0] o_y
);

    import slrg_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_vld;
    logic [VAL_W:0]    fold_sum;
    logic [VAL_W:0]    fold_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start;
        end
        if (i_start) begin
            r_prod <= PROD_W'(i_x) * PROD_W'(LCG_MULT);
        end
    end

    // Since 2^31 is 1 modulo the modulus, the high part folds onto the low part;
    // the sum stays below twice the modulus, so one subtraction finishes it.
    always_comb begin
        fold_sum = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
        if (fold_sum >= LCG_MOD) begin
            fold_red = fold_sum - LCG_MOD;
        end else begin
            fold_red = fold_sum;
        end
    end

    assign o_valid = r_vld;
    assign o_y     = fold_red[VAL_W-1:0];

    `SLRG_ASSERT_IMP(a_fold_reduced, r_vld, o_y != '1, "fold result not reduced")

endmodule

`default_nettype wire

>>> rtl/slrg_frac.sv
// Conversion of a generator value to an unsigned Q0.24 fraction of the modulus.
// Depends on slrg_pkg.
`default_nettype none

module slrg_frac (
    input  wire logic [slrg_pkg::VAL_W-1:0]  i_raw,
    output      logic [slrg_pkg::FRAC_W-1:0] o_fraction
);

    import slrg_pkg::*;

    logic [FRAC_W-1:0] quo_lo;
    logic [VAL_W:0]    rem_sum;
    logic [FRAC_W:0]   quo;

    // raw * 2^24 = quo_lo * 2^31 + low bits, and 2^31 = modulus + 1, so the
    // remainder candidate is quo_lo plus the low bits, below twice the modulus.
    always_comb begin
        quo_lo  = i_raw[VAL_W-1:FRAC_SHIFT];
        rem_sum = (VAL_W+1)'(quo_lo)
                + {1'b0, i_raw[FRAC_SHIFT-1:0], {FRAC_W{1'b0}}};
        quo     = (FRAC_W+1)'(quo_lo) + (FRAC_W+1)'(rem_sum >= LCG_MOD);
        if (quo > (FRAC_W+1)'(FRAC_MAX)) begin
            o_fraction = FRAC_MAX;
        end else begin
            o_fraction = quo[FRAC_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/shuffled_lcg_random_generator.sv
// Shuffled minimal-standard uniform generator, top level.
// Depends on slrg_pkg, slrg_ram, slrg_lcg, slrg_frac and assert_macros.svh.
//
// Usage: an input transfer carries cmd and seed. cmd 0 draws the next value;
// cmd 1 reloads the generator from seed (zero or the modulus count as one),
// warms it up and fills the shuffle table, then draws. A draw issued before
// any seed first seeds with one. Every input transfer yields exactly one
// output transfer holding raw_value and its Q0.24 fraction.
// Timing: a plain draw goes from the accepting idle state through the fold
// state back to idle, paced by the multiply-and-fold of the generator core,
// with the table read overlapping the multiply and the write-back overlapping
// the fold. The fold state loads its result into the output register, or into
// the holding register if that stalls. A reseed runs 40 core steps before its draw.
// Reset clears the sequencer, the generator value and the shuffle output, so
// the first draw after reset seeds itself. The table needs no clearing since
// seeding writes every entry before a draw reads one.
// A stalled receiver keeps the output register full; one more result can wait
// in a holding register, after which o_in_stall stays high until it drains.
`default_nettype none
`include "assert_macros.svh"

module shuffled_lcg_random_generator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire slrg_pkg::t_in_item  i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      slrg_pkg::t_out_item o_out_data
);

    import slrg_pkg::*;

    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(SEED_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_TBL  = CNT_W'(TABLE_DEPTH);

    t_state           r_state, n_state;
    logic [VAL_W-1:0] r_lcg, n_lcg;
    logic [VAL_W-1:0] r_shuf, n_shuf;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_vld;
    t_out_item        r_out;
    logic             r_pend;
    t_out_item        r_hold;

    t_ctrl            ctrl;
    logic             in_acc;
    logic             reseed;
    logic [VAL_W-1:0] seed_fix;
    logic [IDX_W-1:0] rd_idx;
    logic             lcg_vld;
    logic [VAL_W-1:0] lcg_y;
    logic [VAL_W-1:0] ram_rdata;
    logic [FRAC_W-1:0] frac;
    t_out_item        res;
    logic             out_free;

    // Items are taken only by an idle sequencer with the holding register empty.
    assign o_in_stall = !((r_state == ST_IDLE) && !r_pend);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Reseed on command, or on a draw while the shuffle output is still zero.
    // A draw that seeds itself always starts from one, whatever the seed field holds.
    assign reseed   = i_in_data.cmd || (r_shuf == '0);
    assign seed_fix = (!i_in_data.cmd || (i_in_data.seed == '0)
                       || (i_in_data.seed == LCG_MOD[VAL_W-1:0]))
                    ? VAL_W'(1) : i_in_data.seed;

    // The table entry is picked by the top bits of the current shuffle output.
    assign rd_idx = r_shuf[VAL_W-1 -: IDX_W];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = reseed ? ST_SEED_MUL : ST_DRAW_FOLD;
                end
            end
            ST_SEED_MUL:  n_state = ST_SEED_FOLD;
            ST_SEED_FOLD: n_state = (r_cnt == '0) ? ST_DRAW : ST_SEED_MUL;
            ST_DRAW:      n_state = ST_DRAW_FOLD;
            ST_DRAW_FOLD: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer. A draw starts the core step and reads
    // the selected entry together; the fold cycle writes the new core value back.
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                ctrl.lcg_start = in_acc && !reseed;
                ctrl.ram_re    = in_acc && !reseed;
            end
            ST_SEED_MUL: begin
                ctrl.lcg_start = 1'b1;
            end
            ST_SEED_FOLD: begin
                // Only the last TABLE_DEPTH warm-up values land in the table.
                ctrl.ram_we    = (r_cnt < CNT_TBL);
                ctrl.ram_waddr = r_cnt[IDX_W-1:0];
            end
            ST_DRAW: begin
                ctrl.lcg_start = 1'b1;
                ctrl.ram_re    = 1'b1;
            end
            ST_DRAW_FOLD: begin
                ctrl.ram_we    = 1'b1;
                ctrl.ram_waddr = r_idx;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // Next values of the generator state.
    always_comb begin
        n_lcg  = r_lcg;
        n_shuf = r_shuf;
        n_cnt  = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && reseed) begin
                    n_lcg = seed_fix;
                    n_cnt = CNT_INIT;
                end
            end
            ST_SEED_FOLD: begin
                n_lcg = lcg_y;
                if (r_cnt == '0) begin
                    // The final warm-up value is table entry 0 and the new output.
                    n_shuf = lcg_y;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_DRAW_FOLD: begin
                n_lcg  = lcg_y;
                n_shuf = ram_rdata;
            end
            default: begin
                n_lcg = r_lcg;
            end
        endcase
    end

    assign res.raw_value = ram_rdata;
    assign res.fraction  = frac;
    assign out_free      = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_lcg     <= '0;
            r_shuf    <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lcg   <= n_lcg;
            r_shuf  <= n_shuf;
            r_cnt   <= n_cnt;
            if (out_free) begin
                if (r_pend) begin
                    r_out_vld <= 1'b1;
                    r_pend    <= 1'b0;
                end else begin
                    r_out_vld <= (r_state == ST_DRAW_FOLD);
                end
            end else if (r_state == ST_DRAW_FOLD) begin
                r_pend <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (ctrl.ram_re) begin
            r_idx <= rd_idx;
        end
        if (out_free) begin
            if (r_pend) begin
                r_out <= r_hold;
            end else if (r_state == ST_DRAW_FOLD) begin
                r_out <= res;
            end
        end else if (r_state == ST_DRAW_FOLD) begin
            r_hold <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    slrg_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.lcg_start),
        .i_x     (r_lcg),
        .o_valid (lcg_vld),
        .o_y     (lcg_y)
    );

    slrg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ctrl.ram_we),
        .i_waddr (ctrl.ram_waddr),
        .i_wdata (lcg_y),
        .i_re    (ctrl.ram_re),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    slrg_frac u_frac (
        .i_raw      (ram_rdata),
        .o_fraction (frac)
    );

    `SLRG_ASSERT_IMP(a_fold_no_pend, r_state == ST_DRAW_FOLD, !r_pend, "holding register busy at draw end")
    `SLRG_ASSERT_IMP(a_pend_out_full, r_pend, r_out_vld, "held result while output register empty")
    `SLRG_ASSERT_NXT(a_shuf_nonzero, r_state == ST_DRAW_FOLD, r_shuf != '0, "shuffle output zero after draw")
    `SLRG_ASSERT_IMP(a_core_sync, lcg_vld, (r_state == ST_SEED_FOLD) || (r_state == ST_DRAW_FOLD), "core result outside a fold cycle")

endmodule

`default_nettype wire
